/* hw/rtl/mfd_pkg.sv */
package mfd_pkg;

  localparam int unsigned MotorIdW   = 11;
  localparam int unsigned CmdW       = 8;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned CountW     = 32;
  localparam int unsigned PayloadW   = 64;
  localparam int unsigned EncW       = 16;
  localparam int unsigned TotalW     = 64;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 32;

  // item kinds
  localparam logic OpFrame     = 1'b0;
  localparam logic OpHeartbeat = 1'b1;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgMotorId        = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgTorqueCode     = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgOfflineTimeout = 2'd2;

  // fixed telemetry command bytes
  localparam logic [CmdW-1:0] CmdTelemA2 = 8'hA2;
  localparam logic [CmdW-1:0] CmdTelemLo = 8'hA3;
  localparam logic [CmdW-1:0] CmdTelemHi = 8'hA8;

  localparam logic [MotorIdW-1:0] MotorIdReset        = 11'd321;
  localparam logic [CmdW-1:0]     TorqueCodeReset     = 8'd161;
  localparam logic [TimeW-1:0]    OfflineTimeoutReset = 32'd100;

  typedef struct packed {
    logic                opcode;
    logic [TimeW-1:0]    now_ms;
    logic                bus_ok;
    logic [MotorIdW-1:0] frame_id;
    logic [PayloadW-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic                     accepted;
    logic [CmdW-1:0]          reply_command;
    logic signed [7:0]        temperature;
    logic signed [15:0]       motor_current;
    logic signed [15:0]       speed;
    logic [EncW-1:0]          encoder_raw;
    logic signed [TotalW-1:0] multi_turn_total;
    logic [CountW-1:0]        frame_count;
    logic                     seen_any;
    logic                     is_online;
  } out_item_t;

endpackage

/* hw/rtl/motor_feedback_frame_decoder.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o   | mfd_pkg::in_item_t
// out     | output    | out_valid_o / out_stall_i | mfd_pkg::out_item_t
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Two register stages: input register, then decode/unwrap into the result
// register. One item per cycle is sustained while the output is not stalled.
// The slowest path is the 64-bit multi-turn add (or the 32-bit age compare).
// Reset returns configuration and tracking state to power-up values.
// A stalled output holds both stages; in_stall_o rises only when the input
// register is full and cannot move forward.
module motor_feedback_frame_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mfd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfd_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [mfd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [mfd_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [mfd_pkg::MotorIdW-1:0] motor_id_q;
  logic [mfd_pkg::CmdW-1:0]     torque_code_q;
  logic [mfd_pkg::TimeW-1:0]    offline_timeout_q;

  logic              in_valid_q;
  mfd_pkg::in_item_t in_item_q;
  logic               out_valid_q;
  mfd_pkg::out_item_t out_item_q;
  logic               advance;

  logic                      seen_q, seen_d;
  logic                      online_q, online_d;
  logic                      tracking_q, tracking_d;
  logic [mfd_pkg::TimeW-1:0] last_rx_q, last_rx_d;
  logic [mfd_pkg::CountW-1:0] rx_total_q, rx_total_d;
  logic [mfd_pkg::CmdW-1:0]  last_cmd_q, last_cmd_d;
  logic [7:0]                temp_q, temp_d;
  logic [15:0]               current_q, current_d;
  logic [15:0]               speed_q, speed_d;
  logic [mfd_pkg::EncW-1:0]  prev_enc_q, prev_enc_d;
  logic [mfd_pkg::TotalW-1:0] total_q, total_d;

  logic [mfd_pkg::CmdW-1:0]  cmd;
  logic [mfd_pkg::EncW-1:0]  enc;
  logic [mfd_pkg::EncW-1:0]  enc_step;
  logic [mfd_pkg::TimeW-1:0] age;
  logic                      frame_hit;
  logic                      telem;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_id_q        <= mfd_pkg::MotorIdReset;
      torque_code_q     <= mfd_pkg::TorqueCodeReset;
      offline_timeout_q <= mfd_pkg::OfflineTimeoutReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mfd_pkg::CfgMotorId:        motor_id_q        <= cfg_data_i[mfd_pkg::MotorIdW-1:0];
        mfd_pkg::CfgTorqueCode:     torque_code_q     <= cfg_data_i[mfd_pkg::CmdW-1:0];
        mfd_pkg::CfgOfflineTimeout: offline_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // result stage moves when the output register is empty or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  assign cmd       = in_item_q.payload[7:0];
  assign enc       = in_item_q.payload[63:48];
  assign enc_step  = enc - prev_enc_q;
  assign age       = in_item_q.now_ms - last_rx_q;
  assign frame_hit = (in_item_q.opcode == mfd_pkg::OpFrame) && in_item_q.bus_ok &&
                     (in_item_q.frame_id == motor_id_q);
  assign telem     = (cmd == torque_code_q) || (cmd == mfd_pkg::CmdTelemA2) ||
                     (cmd inside {[mfd_pkg::CmdTelemLo:mfd_pkg::CmdTelemHi]});

  always_comb begin
    seen_d     = seen_q;
    online_d   = online_q;
    tracking_d = tracking_q;
    last_rx_d  = last_rx_q;
    rx_total_d = rx_total_q;
    last_cmd_d = last_cmd_q;
    temp_d     = temp_q;
    current_d  = current_q;
    speed_d    = speed_q;
    prev_enc_d = prev_enc_q;
    total_d    = total_q;
    if (in_item_q.opcode == mfd_pkg::OpHeartbeat) begin
      online_d = seen_q && (age < offline_timeout_q);
    end else if (frame_hit) begin
      last_cmd_d = cmd;
      last_rx_d  = in_item_q.now_ms;
      rx_total_d = rx_total_q + mfd_pkg::CountW'(1);
      seen_d     = 1'b1;
      online_d   = 1'b1;
      if (telem) begin
        temp_d     = in_item_q.payload[15:8];
        current_d  = in_item_q.payload[31:16];
        speed_d    = in_item_q.payload[47:32];
        prev_enc_d = enc;
        tracking_d = 1'b1;
        // first telemetry reply anchors the multi-turn total at zero
        if (!tracking_q) begin
          total_d = '0;
        end else begin
          total_d = total_q + {{(mfd_pkg::TotalW-mfd_pkg::EncW){enc_step[mfd_pkg::EncW-1]}},
                               enc_step};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      online_q   <= 1'b0;
      tracking_q <= 1'b0;
      last_rx_q  <= '0;
      rx_total_q <= '0;
      last_cmd_q <= '0;
      temp_q     <= '0;
      current_q  <= '0;
      speed_q    <= '0;
      prev_enc_q <= '0;
      total_q    <= '0;
    end else if (advance && in_valid_q) begin
      seen_q     <= seen_d;
      online_q   <= online_d;
      tracking_q <= tracking_d;
      last_rx_q  <= last_rx_d;
      rx_total_q <= rx_total_d;
      last_cmd_q <= last_cmd_d;
      temp_q     <= temp_d;
      current_q  <= current_d;
      speed_q    <= speed_d;
      prev_enc_q <= prev_enc_d;
      total_q    <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_item_q.accepted         <= frame_hit;
      out_item_q.reply_command    <= last_cmd_d;
      out_item_q.temperature      <= temp_d;
      out_item_q.motor_current    <= current_d;
      out_item_q.speed            <= speed_d;
      out_item_q.encoder_raw      <= prev_enc_d;
      out_item_q.multi_turn_total <= total_d;
      out_item_q.frame_count      <= rx_total_d;
      out_item_q.seen_any         <= seen_d;
      out_item_q.is_online        <= online_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* tb/tb.sv */
module tb;

  // no register behind this index
  localparam logic [mfd_pkg::CfgIndexW-1:0] CfgUnused = 2'd3;
  localparam int unsigned PhaseItems = 75;
  localparam int unsigned Phases     = 6;

  // Expected decoder state and the queue of replies it predicts.
  class feedback_scoreboard;
    logic [mfd_pkg::MotorIdW-1:0] motor_id;
    logic [mfd_pkg::CmdW-1:0]     torque_code;
    logic [mfd_pkg::TimeW-1:0]    offline_timeout;
    logic                         seen;
    logic                         online;
    logic                         tracking;
    logic [mfd_pkg::TimeW-1:0]    last_rx;
    logic [mfd_pkg::CountW-1:0]   frame_tally;
    logic [mfd_pkg::CmdW-1:0]     last_cmd;
    logic [7:0]                   temp;
    logic [15:0]                  cur;
    logic [15:0]                  spd;
    logic [mfd_pkg::EncW-1:0]     prev_enc;
    logic [mfd_pkg::TotalW-1:0]   turn_total;
    mfd_pkg::out_item_t           expected_replies[$];
    int                           errors;
    int                           items;
    int                           frames_taken;
    int                           ticks;
    int                           replies_checked;

    function new();
      motor_id        = mfd_pkg::MotorIdReset;
      torque_code     = mfd_pkg::TorqueCodeReset;
      offline_timeout = mfd_pkg::OfflineTimeoutReset;
      seen            = 1'b0;
      online          = 1'b0;
      tracking        = 1'b0;
      last_rx         = '0;
      frame_tally     = '0;
      last_cmd        = '0;
      temp            = '0;
      cur             = '0;
      spd             = '0;
      prev_enc        = '0;
      turn_total      = '0;
      errors          = 0;
      items           = 0;
      frames_taken    = 0;
      ticks           = 0;
      replies_checked = 0;
    endfunction

    function void set_register(logic [mfd_pkg::CfgIndexW-1:0] idx,
                               logic [mfd_pkg::CfgDataW-1:0] data);
      case (idx)
        mfd_pkg::CfgMotorId:        motor_id = data[mfd_pkg::MotorIdW-1:0];
        mfd_pkg::CfgTorqueCode:     torque_code = data[mfd_pkg::CmdW-1:0];
        mfd_pkg::CfgOfflineTimeout: offline_timeout = data;
        default: ;
      endcase
    endfunction

    function void note_item(mfd_pkg::in_item_t it);
      mfd_pkg::out_item_t        r;
      logic [mfd_pkg::CmdW-1:0]  cmd;
      logic [mfd_pkg::EncW-1:0]  enc;
      logic [mfd_pkg::EncW-1:0]  step;
      logic [mfd_pkg::TimeW-1:0] age;
      cmd = it.payload[7:0];
      enc = it.payload[63:48];
      r = '0;
      items++;
      if (it.opcode == mfd_pkg::OpFrame) begin
        if (it.bus_ok && it.frame_id == motor_id) begin
          r.accepted = 1'b1;
          frames_taken++;
          last_cmd    = cmd;
          last_rx     = it.now_ms;
          frame_tally = frame_tally + mfd_pkg::CountW'(1);
          seen        = 1'b1;
          online      = 1'b1;
          if (cmd == torque_code || cmd == mfd_pkg::CmdTelemA2 ||
              (cmd >= mfd_pkg::CmdTelemLo && cmd <= mfd_pkg::CmdTelemHi)) begin
            temp = it.payload[15:8];
            cur  = it.payload[31:16];
            spd  = it.payload[47:32];
            // first telemetry reply anchors the multi-turn count at zero
            if (!tracking) begin
              turn_total = '0;
              tracking   = 1'b1;
            end else begin
              step = enc - prev_enc;
              turn_total = turn_total +
                           {{(mfd_pkg::TotalW-mfd_pkg::EncW){step[mfd_pkg::EncW-1]}}, step};
            end
            prev_enc = enc;
          end
        end
      end else begin
        ticks++;
        age = it.now_ms - last_rx;
        online = seen && (age < offline_timeout);
      end
      r.reply_command    = last_cmd;
      r.temperature      = temp;
      r.motor_current    = cur;
      r.speed            = spd;
      r.encoder_raw      = prev_enc;
      r.multi_turn_total = turn_total;
      r.frame_count      = frame_tally;
      r.seen_any         = seen;
      r.is_online        = online;
      expected_replies.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 100) $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_reply(mfd_pkg::out_item_t got);
      mfd_pkg::out_item_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $error("reply with nothing expected: %0h", got);
        return;
      end
      want = expected_replies.pop_front();
      replies_checked++;
      compare("accepted", 64'(want.accepted), 64'(got.accepted));
      compare("reply_command", 64'(want.reply_command), 64'(got.reply_command));
      compare("temperature", 64'(want.temperature), 64'(got.temperature));
      compare("motor_current", 64'(want.motor_current), 64'(got.motor_current));
      compare("speed", 64'(want.speed), 64'(got.speed));
      compare("encoder_raw", 64'(want.encoder_raw), 64'(got.encoder_raw));
      compare("multi_turn_total", want.multi_turn_total, got.multi_turn_total);
      compare("frame_count", 64'(want.frame_count), 64'(got.frame_count));
      compare("seen_any", 64'(want.seen_any), 64'(got.seen_any));
      compare("is_online", 64'(want.is_online), 64'(got.is_online));
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  mfd_pkg::in_item_t             in_item_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  mfd_pkg::out_item_t            out_item_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [mfd_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [mfd_pkg::CfgDataW-1:0]  cfg_data_i = '0;

  feedback_scoreboard        sb = new();
  bit                        calm = 1'b0;
  logic [mfd_pkg::TimeW-1:0] ms_now = '0;
  int                        setups = 0;

  motor_feedback_frame_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_reply(out_item_o);
  end

  // receiver back-pressure: bursts between free-running stretches
  initial begin
    forever begin
      if (calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 60)) @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic mfd_pkg::in_item_t pack_item(logic op, logic [mfd_pkg::TimeW-1:0] now,
                                                  logic bus,
                                                  logic [mfd_pkg::MotorIdW-1:0] id,
                                                  logic [mfd_pkg::PayloadW-1:0] pl);
    mfd_pkg::in_item_t it;
    it.opcode   = op;
    it.now_ms   = now;
    it.bus_ok   = bus;
    it.frame_id = id;
    it.payload  = pl;
    return it;
  endfunction

  task automatic push_item(mfd_pkg::in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [mfd_pkg::CfgIndexW-1:0] idx,
                           logic [mfd_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
  endtask

  task automatic configure(logic [mfd_pkg::CfgDataW-1:0] id, logic [mfd_pkg::CfgDataW-1:0] tq,
                           logic [mfd_pkg::CfgDataW-1:0] tmo, bit poke_unused);
    write_reg(mfd_pkg::CfgMotorId, id);
    write_reg(mfd_pkg::CfgTorqueCode, tq);
    write_reg(mfd_pkg::CfgOfflineTimeout, tmo);
    if (poke_unused) write_reg(CfgUnused, $urandom);
    cfg_valid_i <= 1'b0;
    setups++;
  endtask

  // stop sending and wait until every predicted reply has been checked
  task automatic settle();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_replies.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    if (sb.expected_replies.size() != 0) begin
      sb.errors++;
      $error("%0d replies never arrived", sb.expected_replies.size());
      sb.expected_replies.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic mfd_pkg::in_item_t random_item();
    mfd_pkg::in_item_t        it;
    int                       pick;
    logic [mfd_pkg::CmdW-1:0] cmd;
    ms_now = ms_now + (($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40));
    it = pack_item(mfd_pkg::OpFrame, ms_now, 1'($urandom_range(0, 1)),
                   11'($urandom_range(0, 2047)), {$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // well-formed reply, mostly telemetry with a plausible encoder move
      it.bus_ok   = 1'b1;
      it.frame_id = sb.motor_id;
      case ($urandom_range(0, 4))
        0:       cmd = sb.torque_code;
        1:       cmd = mfd_pkg::CmdTelemA2;
        2, 3:    cmd = 8'($urandom_range(mfd_pkg::CmdTelemLo, mfd_pkg::CmdTelemHi));
        default: cmd = 8'($urandom);
      endcase
      it.payload[7:0] = cmd;
      if ($urandom_range(0, 3) != 0)
        it.payload[63:48] = 16'(sb.prev_enc + $urandom_range(0, 4000) - 16'd2000);
    end else if (pick < 60) begin
      // near miss: right id on the wrong bus, or one id bit off
      if ($urandom_range(0, 1)) begin
        it.bus_ok   = 1'b0;
        it.frame_id = sb.motor_id;
      end else begin
        it.bus_ok   = 1'b1;
        it.frame_id = sb.motor_id ^ (11'd1 << $urandom_range(0, 10));
      end
      if ($urandom_range(0, 1)) it.payload[7:0] = mfd_pkg::CmdTelemA2;
    end else if (pick < 90) begin
      it.opcode = mfd_pkg::OpHeartbeat;
      if ($urandom_range(0, 2) == 0)
        it.now_ms = sb.last_rx + sb.offline_timeout - $urandom_range(0, 2);
    end else begin
      it.opcode = 1'($urandom_range(0, 1));
      it.now_ms = $urandom;
    end
    return it;
  endfunction

  initial begin
    logic [mfd_pkg::TimeW-1:0] t;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // power-up settings
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'd0, 1'b0, 11'd0, 64'd0));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd10, 1'b0, mfd_pkg::MotorIdReset,
                        {16'h1234, 40'd0, mfd_pkg::CmdTelemA2}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd11, 1'b1, mfd_pkg::MotorIdReset - 11'd1,
                        {16'h1234, 40'd0, mfd_pkg::CmdTelemA2}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd20, 1'b1, mfd_pkg::MotorIdReset,
                        {56'hFF_FFFF_FFFF_FFFF, 8'h00}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd30, 1'b1, mfd_pkg::MotorIdReset,
                        {16'hFFFF, 16'h7FFF, 16'h8000, 8'h80, mfd_pkg::CmdTelemA2}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd40, 1'b1, mfd_pkg::MotorIdReset,
                        {16'h0000, 16'h8000, 16'h7FFF, 8'h7F, mfd_pkg::CmdTelemLo}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd50, 1'b1, mfd_pkg::MotorIdReset,
                        {16'h8000, 16'h0001, 16'hFFFF, 8'hFF, mfd_pkg::CmdTelemHi}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd60, 1'b1, mfd_pkg::MotorIdReset,
                        {16'h7FFF, 16'hFFFF, 16'h0001, 8'h01, mfd_pkg::TorqueCodeReset}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd70, 1'b1, mfd_pkg::MotorIdReset,
                        {16'hFFFF, 40'd0, 8'hA9}));
    push_item(pack_item(mfd_pkg::OpFrame, 32'd75, 1'b1, 11'h7FF, '1));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'd169, 1'b1, mfd_pkg::MotorIdReset, '1));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'd170, 1'b0, 11'd0, 64'd0));
    // receive time just before the millisecond counter wraps
    push_item(pack_item(mfd_pkg::OpFrame, 32'hFFFF_FFF0, 1'b1, mfd_pkg::MotorIdReset,
                        {16'h0001, 40'h12_3456_789A, 8'hA5}));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'h0000_0010, 1'b0, 11'd0, 64'd0));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'hFFFF_FFEF, 1'b0, 11'd0, 64'd0));
    push_item(pack_item(mfd_pkg::OpFrame, 32'hFFFF_FFFF, 1'b1, mfd_pkg::MotorIdReset, '1));
    settle();

    // all-ones settings: any byte-FF frame is telemetry, timeout at its maximum
    configure('1, '1, '1, 1'b0);
    push_item(pack_item(mfd_pkg::OpFrame, 32'd0, 1'b1, 11'h7FF, '1));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'hFFFF_FFFE, 1'b0, 11'd0, 64'd0));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'hFFFF_FFFF, 1'b0, 11'd0, 64'd0));
    settle();

    // zero settings: a zero timeout keeps every heartbeat offline
    configure('0, '0, '0, 1'b1);
    push_item(pack_item(mfd_pkg::OpFrame, 32'd5, 1'b1, 11'd0, 64'd0));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'd5, 1'b0, 11'd0, 64'd0));
    settle();
    write_reg(mfd_pkg::CfgOfflineTimeout, 32'd1);
    cfg_valid_i <= 1'b0;
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'd5, 1'b0, 11'd0, 64'd0));
    push_item(pack_item(mfd_pkg::OpHeartbeat, 32'd6, 1'b0, 11'd0, 64'd0));
    settle();

    for (int ph = 0; ph < Phases; ph++) begin
      case ($urandom_range(0, 4))
        0:       t = 32'd1;
        1:       t = $urandom_range(1, 300);
        2:       t = '1;
        3:       t = $urandom;
        default: t = $urandom_range(20, 2000);
      endcase
      if (ph == Phases - 1) calm = 1'b1;
      configure($urandom, $urandom, t, 1'($urandom_range(0, 1)));
      repeat (PhaseItems) push_item(random_item());
      settle();
    end

    $display("decoded %0d items: %0d frames taken, %0d heartbeats, %0d replies checked",
             sb.items, sb.frames_taken, sb.ticks, sb.replies_checked);
    $display("%0d register setups, zero and all-ones timeouts among them", setups);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
